// ===== src/eabv_pkg.sv =====
package eabv_pkg;

  localparam int OUT_FRAC_BITS = 14;
  localparam int TRIG_STEPS    = 16;
  localparam int WF            = 30;

  localparam int ANGLE_LIMIT = 23040;
  localparam int MAG_W       = 15;
  localparam int U_W         = 20;
  localparam int P_W         = 33;
  localparam int Q_W         = 14;
  localparam int RECIP_SH    = 26;
  localparam int DIV_CONST   = 45;

  // 2^23 = 45 * T_MUL + 23, so mag * 2^23 / 45 splits into an exact product
  // and a small quotient that a reciprocal multiply resolves.
  localparam logic [17:0] T_MUL   = 18'd186413;
  localparam logic [20:0] RECIP45 = 21'd1491308;

  typedef logic signed [15:0] angle_t;
  typedef logic signed [33:0] cw_t;
  typedef logic signed [31:0] tw_t;
  typedef logic signed [15:0] comp_t;

  localparam cw_t CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    angle_t pitch_angle;
    angle_t yaw_angle;
    angle_t roll_angle;
  } angles_t;

  typedef struct packed {
    cw_t  x;
    cw_t  y;
    cw_t  z;
    logic flip;
  } lane_t;

  typedef struct packed {
    lane_t pitch;
    lane_t yaw;
    lane_t roll;
  } trio_t;

  typedef struct packed {
    comp_t forward_x;
    comp_t forward_y;
    comp_t forward_z;
    comp_t right_x;
    comp_t right_y;
    comp_t right_z;
    comp_t up_x;
    comp_t up_y;
    comp_t up_z;
  } basis_t;

  function automatic cw_t atan_val(input int i);
    case (i)
      0:       atan_val = 34'sd536870912;
      1:       atan_val = 34'sd316933406;
      2:       atan_val = 34'sd167458907;
      3:       atan_val = 34'sd85004756;
      4:       atan_val = 34'sd42667331;
      5:       atan_val = 34'sd21354465;
      6:       atan_val = 34'sd10679838;
      7:       atan_val = 34'sd5340245;
      8:       atan_val = 34'sd2670163;
      9:       atan_val = 34'sd1335087;
      10:      atan_val = 34'sd667544;
      11:      atan_val = 34'sd333772;
      12:      atan_val = 34'sd166886;
      13:      atan_val = 34'sd83443;
      14:      atan_val = 34'sd41722;
      15:      atan_val = 34'sd20861;
      16:      atan_val = 34'sd10430;
      17:      atan_val = 34'sd5215;
      18:      atan_val = 34'sd2608;
      19:      atan_val = 34'sd1304;
      20:      atan_val = 34'sd652;
      21:      atan_val = 34'sd326;
      22:      atan_val = 34'sd163;
      23:      atan_val = 34'sd81;
      24:      atan_val = 34'sd41;
      25:      atan_val = 34'sd20;
      26:      atan_val = 34'sd10;
      27:      atan_val = 34'sd5;
      28:      atan_val = 34'sd3;
      29:      atan_val = 34'sd1;
      30:      atan_val = 34'sd1;
      default: atan_val = 34'sd0;
    endcase
  endfunction

  // Q2.30 product, rounded to nearest with ties toward plus infinity.
  function automatic tw_t qmul(input tw_t a, input tw_t b);
    logic signed [63:0] p;
    p = a * b;
    p = p + 64'sd536870912;
    qmul = p[61:30];
  endfunction

  function automatic comp_t to_out(input cw_t v);
    localparam int SH = WF - OUT_FRAC_BITS;
    localparam cw_t ONE = 34'sd1 <<< OUT_FRAC_BITS;
    cw_t r;
    if (SH == 0) begin
      r = v;
    end else begin
      r = (v + (34'sd1 <<< (SH - 1))) >>> SH;
    end
    if (r > ONE) r = ONE;
    if (r < -ONE) r = -ONE;
    if (r > 34'sd32767) r = 34'sd32767;
    if (r < -34'sd32768) r = -34'sd32768;
    to_out = r[15:0];
  endfunction

endpackage

// ===== src/eabv_in_if.sv =====
interface eabv_in_if;
  import eabv_pkg::*;
  logic   valid;
  logic   ready;
  angle_t pitch_angle;
  angle_t yaw_angle;
  angle_t roll_angle;

  modport source (output valid, output pitch_angle, output yaw_angle, output roll_angle,
                  input ready);
  modport sink (input valid, input pitch_angle, input yaw_angle, input roll_angle,
                output ready);
endinterface

// ===== src/eabv_out_if.sv =====
interface eabv_out_if;
  import eabv_pkg::*;
  logic  valid;
  logic  ready;
  comp_t forward_x;
  comp_t forward_y;
  comp_t forward_z;
  comp_t right_x;
  comp_t right_y;
  comp_t right_z;
  comp_t up_x;
  comp_t up_y;
  comp_t up_z;

  modport source (output valid, output forward_x, output forward_y, output forward_z,
                  output right_x, output right_y, output right_z,
                  output up_x, output up_y, output up_z, input ready);
  modport sink (input valid, input forward_x, input forward_y, input forward_z,
                input right_x, input right_y, input right_z,
                input up_x, input up_y, input up_z, output ready);
endinterface

// ===== src/euler_angles_to_basis_vectors_core.sv =====
// Items pass through prep, the TRIG_STEPS CORDIC stages (one item each) and combine.
// Throughput: one item per cycle while the output is not stalled.
// Every stage has its own valid bit, so a stalled output only halts the stages behind it
// once they fill, and empty stages keep taking items.
// Reset: rst_ni is asynchronous and active low; it clears all valid bits.
module euler_angles_to_basis_vectors_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  eabv_in_if.sink    in_i,
  eabv_out_if.source out_o
);
  import eabv_pkg::*;

  angles_t angles;
  trio_t   prep_trio;
  trio_t   cordic_trio;
  basis_t  basis;
  logic    prep_valid, prep_ready;
  logic    cordic_valid, cordic_ready;

  assign angles.pitch_angle = in_i.pitch_angle;
  assign angles.yaw_angle   = in_i.yaw_angle;
  assign angles.roll_angle  = in_i.roll_angle;

  eabv_prep u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_i.valid),
    .ready_o  (in_i.ready),
    .angles_i (angles),
    .valid_o  (prep_valid),
    .ready_i  (prep_ready),
    .trio_o   (prep_trio)
  );

  eabv_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .ready_o (prep_ready),
    .trio_i  (prep_trio),
    .valid_o (cordic_valid),
    .ready_i (cordic_ready),
    .trio_o  (cordic_trio)
  );

  eabv_combine u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cordic_valid),
    .ready_o (cordic_ready),
    .trio_i  (cordic_trio),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .basis_o (basis)
  );

  assign out_o.forward_x = basis.forward_x;
  assign out_o.forward_y = basis.forward_y;
  assign out_o.forward_z = basis.forward_z;
  assign out_o.right_x   = basis.right_x;
  assign out_o.right_y   = basis.right_y;
  assign out_o.right_z   = basis.right_z;
  assign out_o.up_x      = basis.up_x;
  assign out_o.up_y      = basis.up_y;
  assign out_o.up_z      = basis.up_z;
endmodule

// ===== src/eabv_prep.sv =====
module eabv_prep (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  eabv_pkg::angles_t angles_i,
  output logic              valid_o,
  input  logic              ready_i,
  output eabv_pkg::trio_t   trio_o
);
  import eabv_pkg::*;

  typedef struct packed {
    logic           neg;
    logic [U_W-1:0] u;
    logic [P_W-1:0] p;
  } s1_t;

  typedef struct packed {
    logic           neg;
    logic [U_W-1:0] u;
    logic [P_W-1:0] p;
    logic [Q_W-1:0] qa;
  } s2_t;

  logic [2:0] v_q;
  logic [3:0] en;
  s1_t        s1_d [3];
  s1_t        s1_q [3];
  s2_t        s2_d [3];
  s2_t        s2_q [3];
  lane_t      s3_d [3];
  lane_t      s3_q [3];
  angle_t     raw  [3];

  assign raw[0] = angles_i.pitch_angle;
  assign raw[1] = angles_i.yaw_angle;
  assign raw[2] = angles_i.roll_angle;

  always_comb begin
    en[3] = ready_i;
    for (int i = 2; i >= 0; i--) en[i] = !v_q[i] || en[i+1];
  end
  assign ready_o = en[0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      angle_t         a;
      logic [MAG_W-1:0] mag;
      logic [40:0]    prod;
      logic [20:0]    rem;
      logic [Q_W:0]   q;
      logic [33:0]    t;
      logic [33:0]    tn;
      cw_t            z;
      a = raw[k];
      if (a > 16'(ANGLE_LIMIT)) a = 16'(ANGLE_LIMIT);
      if (a < -16'(ANGLE_LIMIT)) a = -16'(ANGLE_LIMIT);
      mag = a[15] ? MAG_W'(-a) : a[MAG_W-1:0];
      s1_d[k].neg = a[15];
      s1_d[k].u   = U_W'(mag) * U_W'(23) + U_W'(22);
      s1_d[k].p   = P_W'(mag) * P_W'(T_MUL);

      prod = 41'(s1_q[k].u) * 41'(RECIP45);
      s2_d[k].neg = s1_q[k].neg;
      s2_d[k].u   = s1_q[k].u;
      s2_d[k].p   = s1_q[k].p;
      s2_d[k].qa  = prod[RECIP_SH+Q_W-1:RECIP_SH];

      // The reciprocal underestimates the quotient by at most one.
      rem = 21'(s2_q[k].u) - 21'(s2_q[k].qa) * 21'(DIV_CONST);
      q   = (rem >= 21'(DIV_CONST)) ? (Q_W+1)'(s2_q[k].qa) + 1'b1 : (Q_W+1)'(s2_q[k].qa);
      t   = 34'(s2_q[k].p) + 34'(q);
      tn  = s2_q[k].neg ? -t : t;
      z   = 34'(signed'(tn[31:0]));
      s3_d[k].flip = 1'b0;
      if (z > 34'sd1073741824) begin
        z = z - 34'sd2147483648;
        s3_d[k].flip = 1'b1;
      end else if (z < -34'sd1073741824) begin
        z = z + 34'sd2147483648;
        s3_d[k].flip = 1'b1;
      end
      s3_d[k].x = CORDIC_GAIN;
      s3_d[k].y = '0;
      s3_d[k].z = z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) s1_q <= s1_d;
    if (en[1]) s2_q <= s2_d;
    if (en[2]) s3_q <= s3_d;
  end

  assign valid_o      = v_q[2];
  assign trio_o.pitch = s3_q[0];
  assign trio_o.yaw   = s3_q[1];
  assign trio_o.roll  = s3_q[2];
endmodule

// ===== src/eabv_cordic.sv =====
module eabv_cordic (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  eabv_pkg::trio_t trio_i,
  output logic            valid_o,
  input  logic            ready_i,
  output eabv_pkg::trio_t trio_o
);
  import eabv_pkg::*;

  localparam int N = TRIG_STEPS;

  logic [N-1:0] v_q;
  logic [N:0]   en;
  trio_t        st_q [N];
  trio_t        st_d [N];

  function automatic lane_t rotate(input lane_t l, input int i);
    cw_t   dx;
    cw_t   dy;
    lane_t r;
    dx = l.x >>> i;
    dy = l.y >>> i;
    r  = l;
    if (l.z >= 0) begin
      r.x = l.x - dy;
      r.y = l.y + dx;
      r.z = l.z - atan_val(i);
    end else begin
      r.x = l.x + dy;
      r.y = l.y - dx;
      r.z = l.z + atan_val(i);
    end
    return r;
  endfunction

  always_comb begin
    en[N] = ready_i;
    for (int i = N - 1; i >= 0; i--) en[i] = !v_q[i] || en[i+1];
  end
  assign ready_o = en[0];

  // One micro-rotation per stage; all three angles go through side by side.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      trio_t src;
      src = (i == 0) ? trio_i : st_q[(i == 0) ? 0 : i - 1];
      st_d[i].pitch = rotate(src.pitch, i);
      st_d[i].yaw   = rotate(src.yaw, i);
      st_d[i].roll  = rotate(src.roll, i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < N; i++) begin
        if (en[i]) v_q[i] <= (i == 0) ? valid_i : v_q[(i == 0) ? 0 : i - 1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < N; i++) begin
      if (en[i]) st_q[i] <= st_d[i];
    end
  end

  assign valid_o = v_q[N-1];
  assign trio_o  = st_q[N-1];
endmodule

// ===== src/eabv_combine.sv =====
module eabv_combine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  eabv_pkg::trio_t  trio_i,
  output logic             valid_o,
  input  logic             ready_i,
  output eabv_pkg::basis_t basis_o
);
  import eabv_pkg::*;

  typedef struct packed {
    cw_t nsp;
    tw_t srsp, crsp, cy, sy;
    tw_t cp_cy, cp_sy, cr_sy, cr_cy, sr_cp, sr_sy, sr_cy, cr_cp;
  } pa_t;

  typedef struct packed {
    cw_t nsp;
    tw_t srsp_cy, srsp_sy, crsp_cy, crsp_sy;
    tw_t cp_cy, cp_sy, cr_sy, cr_cy, sr_cp, sr_sy, sr_cy, cr_cp;
  } pb_t;

  logic [2:0] v_q;
  logic [3:0] en;
  pa_t        a_d, a_q;
  pb_t        b_d, b_q;
  basis_t     c_d, c_q;

  function automatic cw_t fix_sign(input cw_t v, input logic flip);
    return flip ? -v : v;
  endfunction

  always_comb begin
    en[3] = ready_i;
    for (int i = 2; i >= 0; i--) en[i] = !v_q[i] || en[i+1];
  end
  assign ready_o = en[0];

  always_comb begin
    cw_t sp_w, cp_w, sy_w, cy_w, sr_w, cr_w;
    tw_t sp, cp, sr, cr;
    sp_w = fix_sign(trio_i.pitch.y, trio_i.pitch.flip);
    cp_w = fix_sign(trio_i.pitch.x, trio_i.pitch.flip);
    sy_w = fix_sign(trio_i.yaw.y, trio_i.yaw.flip);
    cy_w = fix_sign(trio_i.yaw.x, trio_i.yaw.flip);
    sr_w = fix_sign(trio_i.roll.y, trio_i.roll.flip);
    cr_w = fix_sign(trio_i.roll.x, trio_i.roll.flip);
    sp = sp_w[31:0];
    cp = cp_w[31:0];
    sr = sr_w[31:0];
    cr = cr_w[31:0];
    a_d.nsp   = -sp_w;
    a_d.cy    = cy_w[31:0];
    a_d.sy    = sy_w[31:0];
    a_d.srsp  = qmul(sr, sp);
    a_d.crsp  = qmul(cr, sp);
    a_d.cp_cy = qmul(cp, cy_w[31:0]);
    a_d.cp_sy = qmul(cp, sy_w[31:0]);
    a_d.cr_sy = qmul(cr, sy_w[31:0]);
    a_d.cr_cy = qmul(cr, cy_w[31:0]);
    a_d.sr_cp = qmul(sr, cp);
    a_d.sr_sy = qmul(sr, sy_w[31:0]);
    a_d.sr_cy = qmul(sr, cy_w[31:0]);
    a_d.cr_cp = qmul(cr, cp);

    b_d.nsp     = a_q.nsp;
    b_d.srsp_cy = qmul(a_q.srsp, a_q.cy);
    b_d.srsp_sy = qmul(a_q.srsp, a_q.sy);
    b_d.crsp_cy = qmul(a_q.crsp, a_q.cy);
    b_d.crsp_sy = qmul(a_q.crsp, a_q.sy);
    b_d.cp_cy   = a_q.cp_cy;
    b_d.cp_sy   = a_q.cp_sy;
    b_d.cr_sy   = a_q.cr_sy;
    b_d.cr_cy   = a_q.cr_cy;
    b_d.sr_cp   = a_q.sr_cp;
    b_d.sr_sy   = a_q.sr_sy;
    b_d.sr_cy   = a_q.sr_cy;
    b_d.cr_cp   = a_q.cr_cp;

    c_d.forward_x = to_out(34'(b_q.cp_cy));
    c_d.forward_y = to_out(34'(b_q.cp_sy));
    c_d.forward_z = to_out(b_q.nsp);
    c_d.right_x   = to_out(34'(b_q.cr_sy) - 34'(b_q.srsp_cy));
    c_d.right_y   = to_out(-34'(b_q.srsp_sy) - 34'(b_q.cr_cy));
    c_d.right_z   = to_out(-34'(b_q.sr_cp));
    c_d.up_x      = to_out(34'(b_q.crsp_cy) + 34'(b_q.sr_sy));
    c_d.up_y      = to_out(34'(b_q.crsp_sy) - 34'(b_q.sr_cy));
    c_d.up_z      = to_out(34'(b_q.cr_cp));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) a_q <= a_d;
    if (en[1]) b_q <= b_d;
    if (en[2]) c_q <= c_d;
  end

  assign valid_o = v_q[2];
  assign basis_o = c_q;
endmodule
